/* rtl/rpbs_pkg.sv */
// shared widths, codes and control types for the route prefix search block
package rpbs_pkg;

    localparam int ADDR_W    = 32;
    localparam int SLOT_W    = 10;
    localparam int IN_PORT_W = 4;
    localparam int CNT_REG_W = 11;

    localparam logic FUNC_WRITE  = 1'b0;
    localparam logic FUNC_LOOKUP = 1'b1;

    // controller to datapath
    typedef struct packed {
        logic start;        // load search bounds and destination
        logic step;         // take one probe result
        logic mem_wr;       // write route entry from the request
        logic load_lookup;  // push lookup result to output register
        logic load_write;   // push empty write result to output register
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic search_done;  // bounds have met
        logic out_free;     // output register can take a result
    } t_dp_status;

endpackage

/* rtl/rpbs_chan_if.sv */
// request and response channel interfaces
interface rpbs_req_if;
    import rpbs_pkg::*;

    logic                 valid;
    logic                 ready;
    logic                 func;
    logic [SLOT_W-1:0]    entry_index;
    logic [ADDR_W-1:0]    entry_prefix;
    logic [ADDR_W-1:0]    entry_mask;
    logic [ADDR_W-1:0]    entry_next_hop;
    logic [IN_PORT_W-1:0] entry_port;
    logic [ADDR_W-1:0]    dest_addr;

    modport source (
        output valid, func, entry_index, entry_prefix, entry_mask,
               entry_next_hop, entry_port, dest_addr,
        input  ready
    );
    modport sink (
        input  valid, func, entry_index, entry_prefix, entry_mask,
               entry_next_hop, entry_port, dest_addr,
        output ready
    );
endinterface

interface rpbs_rsp_if;
    import rpbs_pkg::*;

    logic                 valid;
    logic                 ready;
    logic                 found;
    logic [SLOT_W-1:0]    match_index;
    logic [ADDR_W-1:0]    hop_addr;
    logic [IN_PORT_W-1:0] hop_port;

    modport source (
        output valid, found, match_index, hop_addr, hop_port,
        input  ready
    );
    modport sink (
        input  valid, found, match_index, hop_addr, hop_port,
        output ready
    );
endinterface

/* rtl/rpbs_ctrl.sv */
// sequencer for route writes and binary search lookups
module rpbs_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    rpbs_req_if.sink             i_req,
    input  rpbs_pkg::t_dp_status i_status,
    output rpbs_pkg::t_dp_cmd    o_cmd
);
    import rpbs_pkg::*;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SEARCH = 2'd1;
    localparam logic [1:0] ST_WDONE  = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;

    assign i_req.ready = (r_state == ST_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_req.valid) begin
                    if (i_req.func == FUNC_WRITE) begin
                        o_cmd.mem_wr = 1'b1;
                        n_state      = ST_WDONE;
                    end else begin
                        o_cmd.start = 1'b1;
                        n_state     = ST_SEARCH;
                    end
                end
            end
            ST_SEARCH: begin
                if (!i_status.search_done) begin
                    o_cmd.step = 1'b1;
                end else if (i_status.out_free) begin
                    o_cmd.load_lookup = 1'b1;
                    n_state           = ST_IDLE;
                end
            end
            ST_WDONE: begin
                if (i_status.out_free) begin
                    o_cmd.load_write = 1'b1;
                    n_state          = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

/* rtl/rpbs_datapath.sv */
// route memory, search bounds, probe compare and output register
module rpbs_datapath #(
    parameter int TABLE_DEPTH = 1024,
    parameter int PORT_BITS   = 4
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [rpbs_pkg::CNT_REG_W-1:0] i_cfg_wdata,
    rpbs_req_if.sink                       i_req,
    rpbs_rsp_if.source                     o_rsp,
    input  rpbs_pkg::t_dp_cmd              i_cmd,
    output rpbs_pkg::t_dp_status           o_status
);
    import rpbs_pkg::*;

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    typedef struct packed {
        logic [ADDR_W-1:0]    prefix;
        logic [ADDR_W-1:0]    mask;
        logic [ADDR_W-1:0]    hop;
        logic [PORT_BITS-1:0] port;
    } t_route;

    t_route r_mem [TABLE_DEPTH];
    t_route r_rd;

    logic [CNT_REG_W-1:0] r_count;
    logic [CNT_W-1:0]     used_cnt;
    logic [CNT_W-1:0]     r_lo, r_hi, n_lo, n_hi;
    logic [CNT_W-1:0]     cur_mid, nxt_mid;
    logic [CNT_W:0]       cur_sum, nxt_sum;
    logic [ADDR_W-1:0]    r_dest;
    logic [ADDR_W-1:0]    masked;
    logic                 below, hit, wr_en, out_free;

    logic                 r_out_valid;
    logic                 r_found;
    logic [SLOT_W-1:0]    r_match_index;
    logic [ADDR_W-1:0]    r_hop_addr;
    logic [IN_PORT_W-1:0] r_hop_port;

    // route count, clamped to the table depth
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cfg_we) begin
            r_count <= i_cfg_wdata;
        end
    end

    assign used_cnt = (32'(r_count) > 32'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH)
                                                         : CNT_W'(r_count);

    // probe compare on the entry read for the current midpoint
    assign cur_sum = {1'b0, r_lo} + {1'b0, r_hi};
    assign cur_mid = cur_sum[CNT_W:1];
    assign masked  = r_dest & r_rd.mask;
    assign below   = (r_rd.prefix < masked);
    assign hit     = (r_lo < used_cnt) && (masked == r_rd.prefix);

    always_comb begin
        n_lo = r_lo;
        n_hi = r_hi;
        if (i_cmd.start) begin
            n_lo = '0;
            n_hi = used_cnt;
        end else if (i_cmd.step) begin
            if (below) begin
                n_lo = cur_mid + CNT_W'(1);
            end else begin
                n_hi = cur_mid;
            end
        end
    end

    // next midpoint addresses the memory; equals lo once the bounds meet
    assign nxt_sum = {1'b0, n_lo} + {1'b0, n_hi};
    assign nxt_mid = nxt_sum[CNT_W:1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lo <= '0;
            r_hi <= '0;
        end else begin
            r_lo <= n_lo;
            r_hi <= n_hi;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_dest <= i_req.dest_addr;
        end
    end

    // route memory: one write port, one registered read port
    assign wr_en = i_cmd.mem_wr && (32'(i_req.entry_index) < 32'(TABLE_DEPTH));

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[IDX_W'(i_req.entry_index)] <= '{
                prefix: i_req.entry_prefix,
                mask:   i_req.entry_mask,
                hop:    i_req.entry_next_hop,
                port:   PORT_BITS'(i_req.entry_port)
            };
        end
        r_rd <= r_mem[IDX_W'(nxt_mid)];
    end

    // output register
    assign out_free = !r_out_valid || o_rsp.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_lookup || i_cmd.load_write) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_lookup) begin
            r_found       <= hit;
            r_match_index <= hit ? SLOT_W'(r_lo) : '0;
            r_hop_addr    <= hit ? r_rd.hop : '0;
            r_hop_port    <= hit ? IN_PORT_W'(r_rd.port) : '0;
        end else if (i_cmd.load_write) begin
            r_found       <= 1'b0;
            r_match_index <= '0;
            r_hop_addr    <= '0;
            r_hop_port    <= '0;
        end
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.found       = r_found;
    assign o_rsp.match_index = r_match_index;
    assign o_rsp.hop_addr    = r_hop_addr;
    assign o_rsp.hop_port    = r_hop_port;

    assign o_status.search_done = (r_lo == r_hi);
    assign o_status.out_free    = out_free;

    a_bounds_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_lo <= r_hi)
        else $error("search bounds crossed");

    a_step_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.step |=> (r_hi - r_lo) < $past(r_hi - r_lo))
        else $error("probe did not narrow the search range");

    a_found_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.found) |-> (32'(o_rsp.match_index) < 32'(used_cnt)))
        else $error("match index outside the routes in use");

    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.load_lookup || i_cmd.load_write) |-> out_free)
        else $error("result loaded over an untaken result");

endmodule

/* rtl/route_prefix_binary_search.sv */
// top level: ipv4 route table with longest prefix match by binary search
// Software writes route entries (prefix, mask, next hop, interface) by slot with
// request func = write, in sort order (lower masked prefix first, longer mask first
// where prefixes overlap), then sets the number of slots in use through the
// configuration port; the count is clamped to TABLE_DEPTH and should only change
// while no request is in flight. A lookup (func = lookup) runs a lower-bound
// binary search for the first entry whose prefix is not below the destination
// masked by that entry's mask, then reports a match if that masked destination
// equals the prefix. A write transfer returns one response with all fields zero.
// A write occupies the request side until its empty response is loaded into the
// output register. A lookup sets the bounds at the request transfer edge, then
// narrows them with each probe until they meet, then runs the final match check
// and loads the result once the output register is free; the next request
// transfer can come in the cycle after the load. The pace is set by the single read
// port of the route memory, whose registered data feeds one compare per cycle.
// Requests are taken one at a time; a response waiting in the output register
// does not block the next request transfer. Slots that were never written read
// as undefined data and must not lie inside the count in use.
module route_prefix_binary_search #(
    parameter int TABLE_DEPTH = 1024,
    parameter int PORT_BITS   = 4
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [rpbs_pkg::CNT_REG_W-1:0] i_cfg_wdata,
    rpbs_req_if.sink                       i_req,
    rpbs_rsp_if.source                     o_rsp
);
    import rpbs_pkg::*;

    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    // sequencer: accepts requests, steps the search, pushes results
    rpbs_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (i_req),
        .i_status (w_status),
        .o_cmd    (w_cmd)
    );

    // route memory, search bounds and output register
    rpbs_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .PORT_BITS   (PORT_BITS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_req       (i_req),
        .o_rsp       (o_rsp),
        .i_cmd       (w_cmd),
        .o_status    (w_status)
    );

endmodule
